// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Simulation gets concurrent assertions; synthesis sees nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset.
`define ADLP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: %m");

// Condition that must never be seen outside reset.
`define ADLP_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition: %m");

`else

`define ADLP_ASSERT(label, clk, rst, prop)
`define ADLP_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== rtl/core/adlp_pkg.sv =====
package adlp_pkg;

  // Input transfer: one byte of the serialized list.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Output transfer: classification of one byte.
  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] byte_role;
    logic [2:0] addr_kind;
    logic [7:0] addr_index;
    logic       descriptor_done;
    logic [1:0] list_status;
  } out_item_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Byte roles
  localparam logic [2:0] ROLE_TYPE    = 3'd0;
  localparam logic [2:0] ROLE_LENGTH  = 3'd1;
  localparam logic [2:0] ROLE_ADDR    = 3'd2;
  localparam logic [2:0] ROLE_PORT_HI = 3'd3;
  localparam logic [2:0] ROLE_PORT_LO = 3'd4;
  localparam logic [2:0] ROLE_IGNORED = 3'd5;

  // Address kinds
  localparam logic [2:0] KIND_IPV4   = 3'd0;
  localparam logic [2:0] KIND_IPV6   = 3'd1;
  localparam logic [2:0] KIND_ONION2 = 3'd2;
  localparam logic [2:0] KIND_ONION3 = 3'd3;
  localparam logic [2:0] KIND_DNS    = 3'd4;

  // Type byte codes on the wire
  localparam logic [7:0] TYPE_CODE_IPV4   = 8'd1;
  localparam logic [7:0] TYPE_CODE_IPV6   = 8'd2;
  localparam logic [7:0] TYPE_CODE_ONION2 = 8'd3;
  localparam logic [7:0] TYPE_CODE_ONION3 = 8'd4;
  localparam logic [7:0] TYPE_CODE_DNS    = 8'd5;

  // Fixed address lengths
  localparam logic [7:0] LEN_IPV4   = 8'd4;
  localparam logic [7:0] LEN_IPV6   = 8'd16;
  localparam logic [7:0] LEN_ONION2 = 8'd10;
  localparam logic [7:0] LEN_ONION3 = 8'd35;

  // List status
  localparam logic [1:0] STATUS_RUNNING   = 2'd0;
  localparam logic [1:0] STATUS_CLEAN     = 2'd1;
  localparam logic [1:0] STATUS_STOPPED   = 2'd2;
  localparam logic [1:0] STATUS_MALFORMED = 2'd3;

endpackage

// ===== rtl/core/adlp_front.sv =====
// Front part: phase machine that classifies each accepted byte.
module adlp_front import adlp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  q_status_t q_status,
  output logic      push,
  output out_item_t push_data
);

  typedef enum logic [2:0] {
    PH_TYPE  = 3'd0,
    PH_LEN   = 3'd1,
    PH_ADDR  = 3'd2,
    PH_PORTH = 3'd3,
    PH_PORTL = 3'd4,
    PH_STOP  = 3'd5
  } phase_t;

  phase_t     phase, phase_next;
  logic [2:0] kind, kind_next;
  logic [7:0] remain, remain_next;
  logic [7:0] position, position_next;
  logic       known;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  // Classify the byte and work out the next parse state
  always_comb begin
    phase_next    = phase;
    kind_next     = kind;
    remain_next   = remain;
    position_next = position;
    known         = 1'b1;

    push_data                 = '0;
    push_data.byte_out        = in_data.data_byte;
    push_data.byte_role       = ROLE_IGNORED;
    push_data.addr_kind       = KIND_IPV4;
    push_data.addr_index      = 8'd0;
    push_data.descriptor_done = 1'b0;
    push_data.list_status     = STATUS_RUNNING;

    case (phase)
      PH_TYPE: begin
        push_data.byte_role = ROLE_TYPE;
        case (in_data.data_byte)
          TYPE_CODE_IPV4: begin
            kind_next   = KIND_IPV4;
            remain_next = LEN_IPV4;
          end
          TYPE_CODE_IPV6: begin
            kind_next   = KIND_IPV6;
            remain_next = LEN_IPV6;
          end
          TYPE_CODE_ONION2: begin
            kind_next   = KIND_ONION2;
            remain_next = LEN_ONION2;
          end
          TYPE_CODE_ONION3: begin
            kind_next   = KIND_ONION3;
            remain_next = LEN_ONION3;
          end
          TYPE_CODE_DNS: begin
            kind_next   = KIND_DNS;
            remain_next = 8'd0;
          end
          default: begin
            known                 = 1'b0;
            phase_next            = PH_STOP;
            push_data.list_status = STATUS_STOPPED;
          end
        endcase
        if (known) begin
          push_data.addr_kind = kind_next;
          position_next       = 8'd0;
          phase_next          = (kind_next == KIND_DNS) ? PH_LEN : PH_ADDR;
        end
      end
      PH_LEN: begin
        push_data.byte_role = ROLE_LENGTH;
        push_data.addr_kind = kind;
        remain_next         = in_data.data_byte;
        position_next       = 8'd0;
        // empty name skips straight to the port
        phase_next = (in_data.data_byte != 8'd0) ? PH_ADDR : PH_PORTH;
      end
      PH_ADDR: begin
        push_data.byte_role  = ROLE_ADDR;
        push_data.addr_kind  = kind;
        push_data.addr_index = position;
        position_next        = position + 8'd1;
        remain_next          = remain - 8'd1;
        if (remain_next == 8'd0) begin
          phase_next = PH_PORTH;
        end
      end
      PH_PORTH: begin
        push_data.byte_role = ROLE_PORT_HI;
        push_data.addr_kind = kind;
        phase_next          = PH_PORTL;
      end
      PH_PORTL: begin
        push_data.byte_role       = ROLE_PORT_LO;
        push_data.addr_kind       = kind;
        push_data.descriptor_done = 1'b1;
        phase_next                = PH_TYPE;
      end
      default: begin
        push_data.byte_role   = ROLE_IGNORED;
        push_data.list_status = STATUS_STOPPED;
      end
    endcase

    // End of list: report and return to the reset state
    if (in_data.last_byte) begin
      if (phase_next == PH_TYPE) begin
        push_data.list_status = STATUS_CLEAN;
      end else if (phase_next == PH_STOP) begin
        push_data.list_status = STATUS_STOPPED;
      end else begin
        push_data.list_status = STATUS_MALFORMED;
      end
      phase_next    = PH_TYPE;
      kind_next     = KIND_IPV4;
      remain_next   = 8'd0;
      position_next = 8'd0;
    end
  end

  // Parse state, advanced on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_TYPE;
      kind     <= KIND_IPV4;
      remain   <= 8'd0;
      position <= 8'd0;
    end else if (push) begin
      phase    <= phase_next;
      kind     <= kind_next;
      remain   <= remain_next;
      position <= position_next;
    end
  end

endmodule

// ===== rtl/core/adlp_queue.sv =====
`include "assert_macros.svh"

// Short queue between the front and back parts.
module adlp_queue import adlp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_data,
  input  logic      pop,
  output out_item_t head_data,
  output q_status_t status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t       entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign head_data    = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ADLP_NEVER(a_no_overflow, clk, rst, push && status.full)
  `ADLP_NEVER(a_no_underflow, clk, rst, pop && status.empty)
  `ADLP_ASSERT(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1))
  `ADLP_ASSERT(a_ptr_match, clk, rst, status.empty |-> (wr_ptr == rd_ptr))

endmodule

// ===== rtl/core/adlp_back.sv =====
// Back part: output register fed from the queue head.
module adlp_back import adlp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_status_t q_status,
  input  out_item_t head_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Refill when the register is empty or being drained
  assign pop = !q_status.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= head_data;
    end
  end

endmodule

// ===== rtl/core/address_descriptor_list_parser_top.sv =====
// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid / in_ready  | in_data  (in_item_t: byte, last mark)
// output  | out       | out_valid / out_ready| out_data (out_item_t: role, kind, ...)
//
// One byte is accepted per cycle unless the queue is full; each yields one result.
// The front phase machine classifies a byte combinationally, so throughput
// is one transfer per clock while the output side keeps up.
// in_ready drops only when the queue (QUEUE_DEPTH entries) is full.
// Synchronous reset empties the queue and output register and returns the
// parser to expecting a type byte.
module address_descriptor_list_parser_top import adlp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      push;
  logic      pop;
  out_item_t push_data;
  out_item_t head_data;
  q_status_t q_status;

  adlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  adlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .status    (q_status)
  );

  adlp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head_data (head_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
